@@ sv/ssort_pkg.sv @@
// ----------------------------------------------------------------------------
// ssort_pkg
// types and constants shared by the selection sorter
// ----------------------------------------------------------------------------
package ssort_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } ssort_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_result;
    logic               overflowed;
  } ssort_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP
  } ssort_state_t;

endpackage

@@ sv/selection_sorter.sv @@
// ----------------------------------------------------------------------------
// selection_sorter
// collects a list of signed values and returns it in ascending order
// ----------------------------------------------------------------------------
// Elements are loaded one per transfer while busy is low.
// Up to CAPACITY elements are kept; later ones are dropped and the drop is
// reported on the final result. The transfer marked last_item starts the sort,
// and busy stays high until the final result is out. Sorting runs one
// selection pass per output position f of an n element list: a single
// signed comparator walks the element memory from f to n-1, one read per
// cycle, then the swap state writes the displaced front element back
// and drives the minimum as result f. Each result is shown for one cycle
// with result_valid high; the receiver cannot stall it, so it must take
// every transfer.
// ----------------------------------------------------------------------------
module selection_sorter
  import ssort_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  ssort_in_t  item,
  output logic       result_valid,
  output ssort_out_t result
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // element memory, single write port, one registered read port
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  ssort_state_t state, state_next;

  // control and datapath registers
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [IDX_W-1:0]   front;
  logic [IDX_W-1:0]   addr;
  logic               pend;
  logic [IDX_W-1:0]   pend_pos;
  logic signed [31:0] min_val;
  logic [IDX_W-1:0]   min_pos;
  logic signed [31:0] front_val;

  logic               accept;
  logic               has_room;
  logic [IDX_W-1:0]   last_idx;
  logic               first_rd;
  logic               take_new;
  logic signed [31:0] cur_min_val;
  logic [IDX_W-1:0]   cur_min_pos;
  logic signed [31:0] cur_front_val;
  logic               final_pass;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign has_room = (count < CAP_CNT);
  // count is at least one whenever a sort runs
  assign last_idx = IDX_W'(count - CNT_W'(1));

  // fold the freshly read element into the running minimum (first wins ties)
  assign first_rd      = (pend_pos == front);
  assign take_new      = first_rd || (rd_data < min_val);
  assign cur_min_val   = take_new ? rd_data : min_val;
  assign cur_min_pos   = take_new ? pend_pos : min_pos;
  assign cur_front_val = first_rd ? rd_data : front_val;
  assign final_pass    = (front == last_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    wr_addr    = count[IDX_W-1:0];
    wr_data    = item.value;
    rd_addr    = addr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mem_we = has_room;
          if (item.last_item) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (addr == last_idx) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        // old front value moves to where the minimum was
        mem_we  = 1'b1;
        wr_addr = cur_min_pos;
        wr_data = cur_front_val;
        state_next = final_pass ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      front        <= '0;
      addr         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          pend  <= 1'b0;
          front <= '0;
          addr  <= '0;
          if (accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          pend     <= 1'b1;
          pend_pos <= addr;
          if (pend) begin
            min_val   <= cur_min_val;
            min_pos   <= cur_min_pos;
            front_val <= cur_front_val;
          end
          if (addr != last_idx) begin
            addr <= addr + IDX_W'(1);
          end
        end
        ST_SWAP: begin
          result_valid        <= 1'b1;
          result.sorted_value <= cur_min_val;
          result.last_result  <= final_pass;
          result.overflowed   <= final_pass && ovf;
          pend                <= 1'b0;
          if (final_pass) begin
            count <= '0;
            ovf   <= 1'b0;
          end else begin
            front <= front + IDX_W'(1);
            addr  <= front + IDX_W'(1);
          end
        end
        default: pend <= 1'b0;
      endcase
    end
  end

endmodule
